// ===== rtl/alu8_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, command codes and arithmetic helpers for the 8-bit ALU.
// No dependencies; every other file imports this package.
package alu8_pkg;

	localparam int unsigned W = 8;
	localparam int unsigned BOOTH_STEPS = W;
	localparam int unsigned STEPS_PER_STAGE = 2;
	localparam int unsigned N_STAGES = BOOTH_STEPS / STEPS_PER_STAGE;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2
	} cmd_e;

	typedef struct packed {
		logic [W-1:0] sum;
		logic         ovf;
	} add_res_t;

	// Word carried down the pipeline: the command, the Booth registers and the add/sub result.
	typedef struct packed {
		logic [1:0]   cmd;
		logic [W-1:0] m;
		logic [W-1:0] acc;
		logic [W-1:0] q;
		logic         qm1;
		logic         flag;
		logic [W-1:0] as_res;
		logic         as_ovf;
	} stg_t;

	// Add with carry-in; overflow is carry into the top bit XOR carry out.
	function automatic add_res_t add8(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic cin);
		logic [W-1:0] low;
		logic [W:0]   full;
		add_res_t     r;
		low = {1'b0, x[W-2:0]} + {1'b0, y[W-2:0]} + {{(W-1){1'b0}}, cin};
		full = {1'b0, x} + {1'b0, y} + {{W{1'b0}}, cin};
		r.sum = full[W-1:0];
		r.ovf = low[W-1] ^ full[W];
		return r;
	endfunction

	// One radix-2 Booth step: optional add/subtract, then arithmetic shift right.
	function automatic stg_t booth_step(input stg_t s);
		stg_t         r;
		add_res_t     ar;
		logic [W-1:0] acc;
		logic         flag;
		r = s;
		acc = s.acc;
		flag = s.flag;
		if (s.q[0] && !s.qm1) begin
			ar = add8(s.acc, ~s.m, 1'b1);
			acc = ar.sum;
			flag = ar.ovf;
		end else if (!s.q[0] && s.qm1) begin
			ar = add8(s.acc, s.m, 1'b0);
			acc = ar.sum;
			flag = ar.ovf;
		end
		r.acc = {acc[W-1], acc[W-1:1]};
		r.q = {acc[0], s.q[W-1:1]};
		r.qm1 = s.q[0];
		r.flag = flag;
		return r;
	endfunction

endpackage

// ===== rtl/alu8_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the ALU command and result words.
// Depends on alu8_pkg for the data width.
interface alu8_req_if import alu8_pkg::*; ();
	logic         valid;
	logic         ready;
	logic [1:0]   cmd;
	logic [W-1:0] op_a;
	logic [W-1:0] op_b;
	modport source (output valid, output cmd, output op_a, output op_b, input ready);
	modport sink (input valid, input cmd, input op_a, input op_b, output ready);
endinterface

interface alu8_rsp_if import alu8_pkg::*; ();
	logic         valid;
	logic         ready;
	logic [W-1:0] out_a;
	logic [W-1:0] out_q;
	logic         overflow_flag;
	modport source (output valid, output out_a, output out_q, output overflow_flag,
		input ready);
	modport sink (input valid, input out_a, input out_q, input overflow_flag,
		output ready);
endinterface

// ===== rtl/alu8_add_sub_booth_mul.sv =====
`timescale 1ns / 1ps
// Top level of the 8-bit add/subtract/Booth-multiply ALU.
// Depends on alu8_pkg, alu8_if and alu8_booth_stage.

// The ALU takes one command word per clock while the result side is not
// stalled and returns one result word for each, in order. Each word passes
// through the four register stages, which each perform two of the eight Booth
// steps; add and subtract are computed in the first stage and ride along. A
// stall on the result side holds the pipeline, while empty stages keep
// accepting new words. For add and subtract out_q is 0; an unused command code
// gives an all-zero result.
module alu8_add_sub_booth_mul import alu8_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	alu8_req_if.sink   req,
	alu8_rsp_if.source rsp
);

	stg_t     init;
	add_res_t as_r;
	stg_t     data_s [N_STAGES+1];
	logic     valid_s [N_STAGES+1];
	logic     ready_s [N_STAGES+1];
	stg_t     last;

	always_comb begin
		if (req.cmd == CMD_SUB) begin
			as_r = add8(req.op_a, ~req.op_b, 1'b1);
		end else begin
			as_r = add8(req.op_a, req.op_b, 1'b0);
		end
		init.cmd = req.cmd;
		init.m = req.op_b;
		init.acc = '0;
		init.q = req.op_a;
		init.qm1 = 1'b0;
		init.flag = 1'b0;
		init.as_res = as_r.sum;
		init.as_ovf = as_r.ovf;
	end

	assign data_s[0] = init;
	assign valid_s[0] = req.valid;
	assign req.ready = ready_s[0];

	for (genvar k = 0; k < N_STAGES; k++) begin : g_stage
		alu8_booth_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_s[k]),
			.in_ready (ready_s[k]),
			.in_data  (data_s[k]),
			.out_valid(valid_s[k+1]),
			.out_ready(ready_s[k+1]),
			.out_data (data_s[k+1])
		);
	end

	assign last = data_s[N_STAGES];
	assign ready_s[N_STAGES] = rsp.ready;
	assign rsp.valid = valid_s[N_STAGES];

	always_comb begin
		priority if (last.cmd == CMD_MUL) begin
			rsp.out_a = last.acc;
			rsp.out_q = last.q;
			rsp.overflow_flag = last.flag;
		end else if (last.cmd == CMD_ADD || last.cmd == CMD_SUB) begin
			rsp.out_a = last.as_res;
			rsp.out_q = '0;
			rsp.overflow_flag = last.as_ovf;
		end else begin
			rsp.out_a = '0;
			rsp.out_q = '0;
			rsp.overflow_flag = 1'b0;
		end
	end

endmodule

// ===== rtl/alu8_booth_stage.sv =====
`timescale 1ns / 1ps
// One pipeline stage: two Booth steps and the stage register with its valid bit.
// Depends on alu8_pkg for the stage word and the Booth step function.
module alu8_booth_stage import alu8_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  stg_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output stg_t out_data
);

	logic valid_q;
	stg_t data_q;
	stg_t stepped;

	always_comb begin
		stepped = in_data;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			stepped = booth_step(stepped);
		end
	end

	// The stage takes a word when empty or when its word leaves this cycle.
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= stepped;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

`ifndef ASSERT_OFF
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |=> valid_q && $stable(data_q))
		else $error("stalled stage word changed");
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> in_ready)
		else $error("empty stage refused a word");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_q)
		else $error("accepted word lost its valid bit");
`endif

endmodule
